// ----- src/lru_pkg.sv -----
// Shared constants and types for the LRU page cache.
package lru_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int PAGE_W      = 16;
    localparam int CAP_W       = 4;
    localparam int MISS_W      = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int IN_W        = 16;
    localparam int OUT_W       = 40;
    localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(8);
    localparam logic [MISS_W-1:0] MISS_MAX  = '1;

    typedef logic [PAGE_W-1:0] page_t;

    // Lookup outcome handed from the tag compare to the list update.
    typedef struct packed {
        logic                   hit;
        logic [MAX_ENTRIES-1:0] shift_mask;
    } match_t;

endpackage

// ----- src/lru_match.sv -----
// Parallel tag compare over the resident pages, with the shift mask for a hit.
module lru_match
(
    input  lru_pkg::page_t                   page,
    input  lru_pkg::page_t [lru_pkg::MAX_ENTRIES-1:0] list,
    input  logic [lru_pkg::CNT_W-1:0]        occupancy,
    output lru_pkg::match_t                  match
);
    import lru_pkg::*;

    logic [MAX_ENTRIES-1:0] eq;
    logic                   seen;

    always_comb
    begin
        seen = 1'b0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            // only slots below the fill count hold written pages
            eq[i] = (CNT_W'(i) < occupancy) && (list[i] == page);
            seen  = seen | eq[i];
            match.shift_mask[i] = seen;
        end
        match.hit = seen;
    end

endmodule

// ----- src/lru_update.sv -----
// Next recency list, fill count and eviction report for one request.
module lru_update
(
    input  lru_pkg::page_t                   page,
    input  lru_pkg::page_t [lru_pkg::MAX_ENTRIES-1:0] list,
    input  logic [lru_pkg::CNT_W-1:0]        occupancy,
    input  logic [lru_pkg::CNT_W-1:0]        cap_eff,
    input  lru_pkg::match_t                  match,
    output lru_pkg::page_t [lru_pkg::MAX_ENTRIES-1:0] list_next,
    output logic [lru_pkg::CNT_W-1:0]        occupancy_next,
    output logic                             evicted,
    output lru_pkg::page_t                   victim_page
);
    import lru_pkg::*;

    page_t [MAX_ENTRIES-1:0] list_up;
    logic                    full;
    logic [CNT_W-1:0]        last;
    logic                    shift;

    for (genvar g = 0; g < MAX_ENTRIES; g++)
    begin : g_up
        if (g < MAX_ENTRIES - 1)
        begin : g_mid
            assign list_up[g] = list[g+1];
        end
        else
        begin : g_top
            assign list_up[g] = list[g];
        end
    end

    always_comb
    begin
        full           = !match.hit && (occupancy >= cap_eff);
        evicted        = full;
        victim_page    = full ? list[0] : '0;
        last           = (match.hit || full) ? occupancy - CNT_W'(1) : occupancy;
        occupancy_next = (match.hit || full) ? occupancy : occupancy + CNT_W'(1);
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            shift = match.hit ? match.shift_mask[i] : full;
            if (CNT_W'(i) == last)
                list_next[i] = page;
            else if ((CNT_W'(i) < last) && shift)
                list_next[i] = list_up[i];
            else
                list_next[i] = list[i];
        end
    end

endmodule

// ----- src/lru_cache_replacement.sv -----
// Top level of the fully associative LRU page cache.
//
// Each input transaction carries one page number; each request yields exactly
// one output transaction with hit, evicted, victim_page (zero unless evicted)
// and a saturating 16-bit miss_total that counts this request. The block
// sustains one request per clock unless the output stalls: the request is
// captured in an input register, the tag compare and the recency-list shift
// run as combinational logic, and the result lands in an output register
// while the list, fill count and miss counter update at the same edge.
// m_axis_tvalid rises when the held request moves to the output register;
// a new request can enter while a result waits for m_axis_tready. The cache
// starts empty after reset. cfg_wr_data sets the number of slots in use
// (zero acts as one, values above the built entry count act as the entry
// count); write it only while no request is in flight. Lowering it below the
// current fill keeps resident pages, and each later miss evicts only the
// least-recent page.
module lru_cache_replacement
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lru_pkg::CAP_W-1:0]   cfg_wr_data,    // capacity
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lru_pkg::IN_W-1:0]    s_axis_tdata,   // [15:0] page
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lru_pkg::OUT_W-1:0]   m_axis_tdata    // [0] hit, [1] evicted,
                                                        // [17:2] victim_page,
                                                        // [33:18] miss_total
);
    import lru_pkg::*;

    // configuration
    logic [CAP_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        cap_eff;
    logic [CMP_W-1:0]        cap_wide;

    // input stage
    logic                    in_valid_reg;
    page_t                   page_reg;

    // cache state
    page_t [MAX_ENTRIES-1:0] list_reg;
    page_t [MAX_ENTRIES-1:0] list_next;
    logic [CNT_W-1:0]        occ_reg;
    logic [CNT_W-1:0]        occ_next;
    logic [MISS_W-1:0]       miss_reg;
    logic [MISS_W-1:0]       miss_next;

    // result stage
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    match_t                  match;
    logic                    evicted;
    page_t                   victim_page;
    logic                    advance;

    // Move the held request into the result register when that slot frees up.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Clamp the programmed capacity into 1..MAX_ENTRIES.
    always_comb
    begin
        cap_wide = CMP_W'(cap_reg);
        if (cap_reg == '0)
            cap_eff = CNT_W'(1);
        else if (cap_wide > CMP_W'(MAX_ENTRIES))
            cap_eff = CNT_W'(MAX_ENTRIES);
        else
            cap_eff = CNT_W'(cap_wide);
    end

    lru_match u_match
    (
        .page      (page_reg),
        .list      (list_reg),
        .occupancy (occ_reg),
        .match     (match)
    );

    lru_update u_update
    (
        .page           (page_reg),
        .list           (list_reg),
        .occupancy      (occ_reg),
        .cap_eff        (cap_eff),
        .match          (match),
        .list_next      (list_next),
        .occupancy_next (occ_next),
        .evicted        (evicted),
        .victim_page    (victim_page)
    );

    // Count misses, hold at the top value.
    assign miss_next = (!match.hit && (miss_reg != MISS_MAX)) ? miss_reg + MISS_W'(1)
                                                              : miss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                occ_reg       <= occ_next;
                miss_reg      <= miss_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            page_reg <= s_axis_tdata[PAGE_W-1:0];
        if (advance)
        begin
            list_reg     <= list_next;
            out_data_reg <= {(OUT_W - 2 - PAGE_W - MISS_W)'(0), miss_next, victim_page,
                             evicted, match.hit};
        end
    end

    // Fill count never passes the built entry count.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(MAX_ENTRIES))
        else $error("occupancy above entry count");

    // Pages are never dropped without a replacement, so the fill never shrinks.
    a_occ_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> occ_reg >= $past(occ_reg))
        else $error("occupancy decreased");

    // A result is never both a hit and an eviction.
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg[0] && out_data_reg[1]))
        else $error("hit and eviction together");

    // A processed miss below saturation bumps the counter by one.
    a_miss_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !match.hit && (miss_reg != MISS_MAX))
        |=> miss_reg == $past(miss_reg) + MISS_W'(1))
        else $error("miss counter did not advance");

endmodule

// ----- test/lru_result_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the LRU page cache: predicts every lookup and checks the result stream.
module lru_result_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [lru_pkg::CAP_W-1:0]   cfg_wr_data,    // capacity
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [lru_pkg::IN_W-1:0]    s_axis_tdata,   // [15:0] page
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [lru_pkg::OUT_W-1:0]   m_axis_tdata,   // [0] hit, [1] evicted,
                                                        // [17:2] victim_page,
                                                        // [33:18] miss_total
    output int                          fail_count,
    output int                          pending
);

    import lru_pkg::*;

    localparam int PAD_W = OUT_W - 2 - PAGE_W - MISS_W;

    // Result word, first field in the highest bits.
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [MISS_W-1:0] miss_total;
        page_t             victim_page;
        logic              evicted;
        logic              hit;
    } lookup_word_t;

    page_t             recency [MAX_ENTRIES];  // oldest first
    int                fill;
    logic [MISS_W-1:0] misses;
    logic [CAP_W-1:0]  slots_cfg;
    lookup_word_t      expected_lookups [$];
    lookup_word_t      seen;
    lookup_word_t      want;
    int                mismatches;

    // Look one page up in the cache copy and update it; return the expected result.
    function automatic lookup_word_t lookup_page(input page_t page);
        lookup_word_t r;
        int           limit;
        int           where;
        r = '0;
        limit = (slots_cfg == 0) ? 1
              : ((slots_cfg > MAX_ENTRIES) ? MAX_ENTRIES : int'(slots_cfg));
        where = -1;
        for (int i = 0; i < fill; i++)
        begin
            if (where < 0 && recency[i] == page)
                where = i;
        end
        if (where >= 0)
        begin
            r.hit = 1'b1;
            for (int i = where; i + 1 < fill; i++)
                recency[i] = recency[i + 1];
            recency[fill - 1] = page;
        end
        else
        begin
            if (misses != MISS_MAX)
                misses = misses + 1'b1;
            if (fill >= limit)
            begin
                // Full, or capacity lowered below the fill: drop the oldest page only.
                r.evicted     = 1'b1;
                r.victim_page = recency[0];
                for (int i = 0; i + 1 < fill; i++)
                    recency[i] = recency[i + 1];
                recency[fill - 1] = page;
            end
            else
            begin
                recency[fill] = page;
                fill = fill + 1;
            end
        end
        r.miss_total = misses;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            mismatches = mismatches + 1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                recency[i] = '0;
            fill       = 0;
            misses     = '0;
            slots_cfg  = CAP_RESET;
            mismatches = 0;
            expected_lookups.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                slots_cfg = cfg_wr_data;
            // Retire the result transaction before taking a new request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = m_axis_tdata;
                if (expected_lookups.size() == 0)
                begin
                    $error("result transaction with no request waiting: %h", m_axis_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_lookups.pop_front();
                    check_field("hit", 32'(want.hit), 32'(seen.hit));
                    check_field("evicted", 32'(want.evicted), 32'(seen.evicted));
                    check_field("victim_page", 32'(want.victim_page),
                                32'(seen.victim_page));
                    check_field("miss_total", 32'(want.miss_total),
                                32'(seen.miss_total));
                end
            end
            // Append the prediction at the tail of the queue.
            if (s_axis_tvalid && s_axis_tready)
                expected_lookups = {expected_lookups,
                                    lookup_page(s_axis_tdata[PAGE_W-1:0])};
            pending    <= expected_lookups.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ----- test/lru_cache_replacement_tb.sv -----
`timescale 1ns / 1ps
// Top of the LRU page cache testbench: clock, reset, request and result traffic, verdict.
module lru_cache_replacement_tb;

    import lru_pkg::*;

    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int HOLD_CYCLES   = 80;      // long result hold-off to back up the pipe
    localparam int HOLD_ITEMS    = 48;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int TAIL_ITEMS    = 100;     // distinct pages streamed in the last part
    localparam int DRAIN_CYCLES  = 10;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CAP_W-1:0]   cfg_wr_data;        // capacity
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;       // [15:0] page
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;       // [0] hit, [1] evicted, [17:2] victim_page,
                                            // [33:18] miss_total
    int                 fail_count;
    int                 pending;

    // Sender idling is owned by the stimulus process; receiver controls cross
    // processes and so change only by nonblocking assignment.
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    bit                 hold_req;
    bit                 hold_done;
    int                 rx_burst;

    lru_cache_replacement u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lru_result_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Hard stop in case a transaction never completes.
    initial
    begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        rx_burst  = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                // Hold off long enough for the block to fill and drop s_axis_tready.
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
                hold_done = 1'b1;
            end
            else
            begin
                if (!hold_req)
                    hold_done = 1'b0;
                if (rx_idle_en && rx_burst == 0 && $urandom_range(0, 3) == 0)
                    rx_burst = $urandom_range(1, 10);
                if (rx_burst > 0)
                begin
                    m_axis_tready <= 1'b0;
                    rx_burst = rx_burst - 1;
                end
                else
                begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    // Offer one page request and return at the edge that accepts it. Leave
    // tvalid high so a following request can go out back to back.
    task automatic send_page(input page_t page);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop tvalid and hold until every predicted result transaction is out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Write the capacity register with the block idle.
    task automatic set_capacity(input logic [CAP_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        page_t            page;
        page_t            pool_base;
        int               pool_size;
        logic [CAP_W-1:0] cap;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        rx_idle_en    <= 1'b0;
        hold_req      <= 1'b0;
        tx_idle_en    = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first request at the reset capacity.
        send_page(16'h0000);

        // Capacity zero behaves as a single slot.
        set_capacity(4'd0);
        send_page(16'hFFFF);
        send_page(16'hFFFF);

        // Smallest legal capacity.
        set_capacity(4'd1);
        send_page(16'hAAAA);
        send_page(16'hAAAA);

        // Mid capacity: fill, evict, then hit the survivors.
        set_capacity(4'd3);
        send_page(16'h5555);
        send_page(16'h0001);
        send_page(16'h8000);
        send_page(16'h5555);
        send_page(16'h0001);

        // Capacity above the built entry count saturates to it; fill all slots, then evict.
        set_capacity(4'd15);
        send_page(16'h7FFF);
        send_page(16'h00FF);
        send_page(16'h1234);
        send_page(16'h4321);
        send_page(16'h0F0F);
        send_page(16'hF0F0);
        send_page(16'h8000);

        // Capacity below the fill: residents stay, each miss drops only the oldest.
        set_capacity(4'd2);
        send_page(16'hBEEF);
        send_page(16'h1234);
        send_page(16'hCAFE);

        // Back to the full width.
        set_capacity(4'd8);
        send_page(16'h0000);
        send_page(16'hFFFF);

        // Random: each phase works a small pool of nearby pages so hits and
        // evictions mix, with some fully random pages as noise.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 4))
                0:       cap = 4'd0;
                1:       cap = 4'd1;
                2:       cap = 4'd8;
                3:       cap = 4'd15;
                default: cap = CAP_W'($urandom_range(2, 7));
            endcase
            set_capacity(cap);
            pool_base = page_t'($urandom());
            pool_size = $urandom_range(2, 16);

            if (ph == 4)
            begin
                // Stall the result side while requests keep coming.
                tx_idle_en = 1'b0;
                hold_req <= 1'b1;
                for (int n = 0; n < HOLD_ITEMS; n++)
                    send_page(pool_base + page_t'($urandom_range(0, pool_size - 1)));
                wait_drained();
                hold_req <= 1'b0;
            end

            // Phase two runs without idling on either side.
            tx_idle_en = (ph != 2);
            rx_idle_en <= (ph != 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    wait_drained();
                if ($urandom_range(0, 7) == 0)
                    page = page_t'($urandom());
                else
                    page = pool_base + page_t'($urandom_range(0, pool_size - 1));
                send_page(page);
            end
        end

        // Last part, no idling: stream distinct pages through a single slot,
        // then one hit on the last page and one more miss.
        tx_idle_en = 1'b0;
        rx_idle_en <= 1'b0;
        set_capacity(4'd1);
        for (int n = 0; n < TAIL_ITEMS; n++)
            send_page(page_t'(n));
        send_page(page_t'(TAIL_ITEMS - 1));
        send_page(16'hFFFF);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/lru_pkg.sv
src/lru_match.sv
src/lru_update.sv
src/lru_cache_replacement.sv
test/lru_result_checker.sv
test/lru_cache_replacement_tb.sv
